### src/bmg_pkg.sv
package bmg_pkg;

	localparam int unsigned CFG_IDX_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_MEAN = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_STD  = CFG_IDX_W'(1);

	localparam logic [31:0] MEAN_RESET = 32'd0;
	localparam logic [31:0] STD_RESET  = 32'd65536;

	// ln 2 in Q0.30 and 2 pi in Q.29.
	localparam logic [29:0] LN2_Q30    = 30'd744261118;
	localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;
	localparam logic [30:0] ONE_Q30    = 31'h4000_0000;

	// Pipeline depths of the radius and cosine units.
	localparam int unsigned RAD_LAT = 65;
	localparam int unsigned COS_LAT = 17;
	localparam int unsigned ALIGN_LAT = RAD_LAT - COS_LAT;

	// Exact floor division by a constant for dividends below 2^31:
	// q = (v * ceil(2^(31+l) / d)) >> (31+l), with 2^l >= d.
	localparam int unsigned DIV_SHIFT [4] = '{38, 37, 36, 34};
	localparam logic [33:0] RCP_COS [4] = '{
		34'(((64'd1 << 38) + 64'd55) / 64'd56),
		34'(((64'd1 << 37) + 64'd29) / 64'd30),
		34'(((64'd1 << 36) + 64'd11) / 64'd12),
		34'(((64'd1 << 34) + 64'd1) / 64'd2)
	};
	localparam logic [33:0] RCP_SIN [4] = '{
		34'(((64'd1 << 38) + 64'd71) / 64'd72),
		34'(((64'd1 << 37) + 64'd41) / 64'd42),
		34'(((64'd1 << 36) + 64'd19) / 64'd20),
		34'(((64'd1 << 34) + 64'd5) / 64'd6)
	};

	typedef struct packed {
		logic [29:0] theta;
		logic [29:0] tsq;
		logic        neg;
		logic        use_sin;
	} angle_t;

	typedef struct packed {
		logic        neg;
		logic [30:0] mag;
	} cosine_t;

	typedef struct packed {
		logic signed [31:0] sample;
		logic               clip;
	} result_t;

endpackage

### src/bmg_if.sv
interface bmg_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] uniform_radius;
	logic [31:0] uniform_angle;

	modport source (output valid, output uniform_radius, output uniform_angle, input ready);
	modport sink (input valid, input uniform_radius, input uniform_angle, output ready);
endinterface

interface bmg_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] gauss_sample;
	logic               clipped;

	modport source (output valid, output gauss_sample, output clipped, input ready);
	modport sink (input valid, input gauss_sample, input clipped, output ready);
endinterface

interface bmg_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [bmg_pkg::CFG_IDX_W-1:0] index;
	logic [31:0]                    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### src/box_muller_gaussian_sample_core.sv
// An accepted word passes the radius and cosine pipelines, two product registers and
// the output register. Throughput: one word per cycle while the skid stage is empty;
// the 65-stage radius pipeline (28 log2 squaring, 32 root stages) sets depth, not rate.
// A two-entry output register and skid stage decouple the output from the pipeline.
// Reset clears all valid bits and loads mean 0.0 and standard deviation 1.0.
module box_muller_gaussian_sample_core #(
	parameter int unsigned UNIFORM_BITS = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	bmg_in_if.sink    uniforms,
	bmg_out_if.source samples,
	bmg_cfg_if.sink   cfg
);

	localparam int unsigned PAD = 32 - UNIFORM_BITS;

	logic [31:0] mean_q;
	logic [31:0] std_q;

	logic        en;
	logic [31:0] turn_r;
	logic [31:0] turn_a;
	logic [30:0] radius;
	bmg_pkg::cosine_t cos_res;
	bmg_pkg::cosine_t cd_s [bmg_pkg::ALIGN_LAT];

	logic        vld_s [bmg_pkg::RAD_LAT];
	logic        vld_t1;
	logic        vld_t2;
	logic [30:0] z_t1;
	logic        neg_t1;
	logic [34:0] y_t2;
	logic        neg_t2;
	logic [61:0] z_prod;
	logic [62:0] y_prod;

	logic signed [36:0] y_sgn;
	logic signed [36:0] sum;
	bmg_pkg::result_t   res;
	bmg_pkg::result_t   od_q;
	bmg_pkg::result_t   sd_q;
	logic               ov_q;
	logic               sv_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mean_q <= bmg_pkg::MEAN_RESET;
			std_q  <= bmg_pkg::STD_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				bmg_pkg::REG_MEAN: mean_q <= cfg.data;
				bmg_pkg::REG_STD:  std_q  <= cfg.data;
				default: ;
			endcase
		end
	end

	assign en             = !sv_q;
	assign uniforms.ready = en;
	assign turn_r         = uniforms.uniform_radius << PAD;
	assign turn_a         = uniforms.uniform_angle << PAD;

	bmg_radius u_radius (
		.clk    (clk),
		.en     (en),
		.turn   (turn_r),
		.radius (radius)
	);

	bmg_cosine u_cosine (
		.clk    (clk),
		.en     (en),
		.turn   (turn_a),
		.result (cos_res)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			cd_s[0] <= cos_res;
			for (int i = 1; i < bmg_pkg::ALIGN_LAT; i++) begin
				cd_s[i] <= cd_s[i-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < bmg_pkg::RAD_LAT; i++) begin
				vld_s[i] <= 1'b0;
			end
			vld_t1 <= 1'b0;
			vld_t2 <= 1'b0;
		end else if (en) begin
			vld_s[0] <= uniforms.valid;
			for (int i = 1; i < bmg_pkg::RAD_LAT; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
			vld_t1 <= vld_s[bmg_pkg::RAD_LAT-1];
			vld_t2 <= vld_t1;
		end
	end

	assign z_prod = radius * cd_s[bmg_pkg::ALIGN_LAT-1].mag;
	assign y_prod = z_t1 * std_q;

	always_ff @(posedge clk) begin
		if (en) begin
			z_t1   <= z_prod[60:30];
			neg_t1 <= cd_s[bmg_pkg::ALIGN_LAT-1].neg;
			y_t2   <= y_prod[62:28];
			neg_t2 <= neg_t1;
		end
	end

	always_comb begin
		y_sgn = neg_t2 ? -$signed({2'b00, y_t2}) : $signed({2'b00, y_t2});
		sum   = y_sgn + $signed({{5{mean_q[31]}}, mean_q});
		if (sum > 37'sh0_7FFF_FFFF) begin
			res.sample = 32'sh7FFF_FFFF;
			res.clip   = 1'b1;
		end else if (sum < -37'sh0_8000_0000) begin
			res.sample = 32'sh8000_0000;
			res.clip   = 1'b1;
		end else begin
			res.sample = sum[31:0];
			res.clip   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			sv_q <= 1'b0;
		end else if (!ov_q || samples.ready) begin
			ov_q <= sv_q || (en && vld_t2);
			sv_q <= 1'b0;
		end else if (en && vld_t2) begin
			sv_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!ov_q || samples.ready) begin
			od_q <= sv_q ? sd_q : res;
		end
		if (ov_q && !samples.ready && en && vld_t2) begin
			sd_q <= res;
		end
	end

	assign samples.valid        = ov_q;
	assign samples.gauss_sample = od_q.sample;
	assign samples.clipped      = od_q.clip;

`ifndef NO_ASSERTIONS
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		sv_q |-> ov_q) else $error("skid word held while output register empty");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sv_q) |-> $past(ov_q && !samples.ready)) else $error("skid filled without stall");

	a_clip_value: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && od_q.clip) |-> (od_q.sample == 32'sh7FFF_FFFF || od_q.sample == 32'sh8000_0000))
		else $error("clipped word not at a limit");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		sv_q |=> $stable(vld_t2)) else $error("pipeline moved during stall");
`endif

endmodule

### src/bmg_radius.sv
module bmg_radius (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] turn,
	output logic [30:0] radius
);

	logic [32:0] w_s1;
	logic [32:0] w_s2;
	logic [5:0]  p_s2;
	logic [31:0] m_s3;
	logic [5:0]  p_s3;
	logic [5:0]  msb_idx;

	logic [31:0] sq_m_s [1:28];
	logic [27:0] sq_f_s [1:28];
	logic [5:0]  sq_p_s [1:28];

	logic [33:0] l2_s32;
	logic [61:0] s_s33;
	logic [63:0] s_prod;

	logic [61:0] x_s  [1:32];
	logic [62:0] rt_s [1:32];

	always_comb begin
		msb_idx = 6'd0;
		for (int i = 0; i < 33; i++) begin
			if (w_s1[i]) begin
				msb_idx = 6'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			w_s1 <= 33'h1_0000_0000 - {1'b0, turn};
			w_s2 <= w_s1;
			p_s2 <= msb_idx;
			m_s3 <= 32'((64'(w_s2) << 31) >> p_s2);
			p_s3 <= p_s2;
		end
	end

	// One squaring per stage yields one fraction bit of log2.
	for (genvar g = 0; g < 28; g++) begin : g_sq
		logic [31:0] m_in;
		logic [27:0] f_in;
		logic [5:0]  p_in;
		logic [63:0] prod;
		logic [32:0] nxt;

		if (g == 0) begin : g_first
			assign m_in = m_s3;
			assign f_in = 28'd0;
			assign p_in = p_s3;
		end else begin : g_rest
			assign m_in = sq_m_s[g];
			assign f_in = sq_f_s[g];
			assign p_in = sq_p_s[g];
		end

		assign prod = m_in * m_in;
		assign nxt  = prod[63:31];

		always_ff @(posedge clk) begin
			if (en) begin
				sq_p_s[g+1] <= p_in;
				if (nxt[32]) begin
					sq_m_s[g+1] <= nxt[32:1];
					sq_f_s[g+1] <= f_in | (28'd1 << (27 - g));
				end else begin
					sq_m_s[g+1] <= nxt[31:0];
					sq_f_s[g+1] <= f_in;
				end
			end
		end
	end

	assign s_prod = l2_s32 * bmg_pkg::LN2_Q30;

	always_ff @(posedge clk) begin
		if (en) begin
			l2_s32 <= {6'(6'd32 - sq_p_s[28]), 28'd0} - {6'd0, sq_f_s[28]};
			s_s33  <= s_prod[62:1];
		end
	end

	// Restoring square root, one result bit per stage.
	for (genvar k = 0; k < 32; k++) begin : g_rt
		localparam logic [62:0] BIT = 63'd1 << (62 - 2 * k);
		logic [61:0] x_in;
		logic [62:0] r_in;
		logic [62:0] trial;

		if (k == 0) begin : g_first
			assign x_in = s_s33;
			assign r_in = 63'd0;
		end else begin : g_rest
			assign x_in = x_s[k];
			assign r_in = rt_s[k];
		end

		assign trial = r_in + BIT;

		always_ff @(posedge clk) begin
			if (en) begin
				if ({1'b0, x_in} >= trial) begin
					x_s[k+1]  <= 62'({1'b0, x_in} - trial);
					rt_s[k+1] <= (r_in >> 1) + BIT;
				end else begin
					x_s[k+1]  <= x_in;
					rt_s[k+1] <= r_in >> 1;
				end
			end
		end
	end

	assign radius = rt_s[32][30:0];

endmodule

### src/bmg_cosine.sv
module bmg_cosine (
	input  logic                     clk,
	input  logic                     en,
	input  logic [31:0]              turn,
	output bmg_pkg::cosine_t         result
);

	logic [31:0] q_s1;
	logic [29:0] q_s2;
	logic        neg_s2;
	logic        sin_s2;
	logic [31:0] q_a;
	logic [31:0] q_b;
	logic [31:0] q_c;
	logic        neg_c;
	logic        sin_c;
	logic [29:0] th_s3;
	logic        neg_s3;
	logic        sin_s3;
	logic [61:0] th_prod;
	logic [59:0] t_prod;
	bmg_pkg::angle_t ang_s4;

	logic [30:0]     va_s  [4];
	logic [30:0]     qd_s  [4];
	logic [30:0]     h_s   [4];
	bmg_pkg::angle_t ang_a [4];
	bmg_pkg::angle_t ang_b [4];
	bmg_pkg::angle_t ang_c [4];

	logic [60:0]     fin_prod;
	bmg_pkg::cosine_t res_s17;

	always_comb begin
		q_a   = q_s1;
		neg_c = q_a > 32'h4000_0000;
		q_b   = neg_c ? 32'h8000_0000 - q_a : q_a;
		sin_c = q_b > 32'h2000_0000;
		q_c   = sin_c ? 32'h4000_0000 - q_b : q_b;
	end

	assign th_prod = q_s2 * bmg_pkg::TWO_PI_Q29;
	assign t_prod  = th_s3 * th_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			q_s1           <= turn[31] ? 32'(33'h1_0000_0000 - {1'b0, turn}) : turn;
			q_s2           <= q_c[29:0];
			neg_s2         <= neg_c;
			sin_s2         <= sin_c;
			th_s3          <= th_prod[60:31];
			neg_s3         <= neg_s2;
			sin_s3         <= sin_s2;
			ang_s4.theta   <= th_s3;
			ang_s4.tsq     <= t_prod[59:30];
			ang_s4.neg     <= neg_s3;
			ang_s4.use_sin <= sin_s3;
		end
	end

	// Nested Taylor form: h = 1 - (t * h) / d, one factor per three stages.
	for (genvar g = 0; g < 4; g++) begin : g_step
		bmg_pkg::angle_t ang_in;
		logic [30:0]     h_in;
		logic [60:0]     th_mul;
		logic [33:0]     rcp;
		logic [64:0]     dprod;

		if (g == 0) begin : g_first
			assign ang_in = ang_s4;
			assign h_in   = bmg_pkg::ONE_Q30;
		end else begin : g_rest
			assign ang_in = ang_c[g-1];
			assign h_in   = h_s[g-1];
		end

		assign th_mul = ang_in.tsq * h_in;
		assign rcp    = ang_a[g].use_sin ? bmg_pkg::RCP_SIN[g] : bmg_pkg::RCP_COS[g];
		assign dprod  = va_s[g] * rcp;

		always_ff @(posedge clk) begin
			if (en) begin
				va_s[g]  <= th_mul[60:30];
				ang_a[g] <= ang_in;
				qd_s[g]  <= 31'(dprod >> bmg_pkg::DIV_SHIFT[g]);
				ang_b[g] <= ang_a[g];
				h_s[g]   <= bmg_pkg::ONE_Q30 - qd_s[g];
				ang_c[g] <= ang_b[g];
			end
		end
	end

	assign fin_prod = ang_c[3].theta * h_s[3];

	always_ff @(posedge clk) begin
		if (en) begin
			res_s17.neg <= ang_c[3].neg;
			res_s17.mag <= ang_c[3].use_sin ? fin_prod[60:30] : h_s[3];
		end
	end

	assign result = res_s17;

endmodule
